>>> src/brl_pkg.sv
`default_nettype none

package brl_pkg;

	localparam int REG_W     = 13;
	localparam int ADDR_W    = 24;
	localparam int CHAN_W    = 8;
	localparam int COLOR_W   = 3 * CHAN_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [REG_W-1:0] RESET_SURFACE_WIDTH  = REG_W'(640);
	localparam logic [REG_W-1:0] RESET_SURFACE_HEIGHT = REG_W'(480);
	localparam logic [REG_W-1:0] RESET_PITCH_WORDS    = REG_W'(640);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SURFACE_WIDTH  = 2'd0,
		REG_SURFACE_HEIGHT = 2'd1,
		REG_PITCH_WORDS    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic last;
		logic write_enable;
		logic stepped;
	} brl_flags_t;

endpackage

`default_nettype wire

>>> src/bresenham_line_rasterizer_top.sv
`default_nettype none

// Bresenham line engine. A load transaction (s_tuser = 0) sets up a line from
// two signed endpoints and an RGB color; each step transaction (s_tuser = 1)
// produces one pixel of that line, end point excluded, with its column, row,
// word address row*pitch_words+col (mod 2^24, zero when off-surface) and the
// packed 0xRRGGBB color. Every input transaction yields exactly one result
// transaction; loads and steps with no active line give stepped = 0 and all
// other fields zero. Throughput is one transaction per clock when m_tready does
// not stall the output, set by the error update of the step loop; each result
// passes an input register, then a result register. Configuration writes
// (0 surface_width, 1 surface_height, 2 pitch_words) take effect at once and
// must only be made while no transaction is in flight.
module bresenham_line_rasterizer_top import brl_pkg::*; #(
	parameter int COORD_BITS = 12,
	localparam int CW    = COORD_BITS + 1,
	localparam int IN_W  = ((4 * CW + COLOR_W) + 7) / 8 * 8,
	localparam int OUT_W = ((2 * CW + ADDR_W + COLOR_W) + 7) / 8 * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// start_x, start_y, end_x, end_y, red, green, blue
	input  wire logic [IN_W-1:0]      s_tdata,
	// req_type
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// pixel_col, pixel_row, word_address, pixel_word
	output logic [OUT_W-1:0]          m_tdata,
	// stepped, write_enable
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	logic                 valid_s1, req_s1;
	logic signed [CW-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic [COLOR_W-1:0]   color_s1;

	logic                 valid_s2;
	brl_flags_t           flags_s2;
	logic signed [CW-1:0] col_s2, row_s2;
	logic [ADDR_W-1:0]    addr_s2;
	logic [COLOR_W-1:0]   word_s2;

	logic                 go, s_fire;
	brl_flags_t           flags;
	logic signed [CW-1:0] pixel_col, pixel_row;
	logic [ADDR_W-1:0]    word_address;
	logic [COLOR_W-1:0]   pixel_word;

	assign go       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || go;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_s1   <= s_tuser;
			sx_s1    <= s_tdata[CW-1:0];
			sy_s1    <= s_tdata[2*CW-1:CW];
			ex_s1    <= s_tdata[3*CW-1:2*CW];
			ey_s1    <= s_tdata[4*CW-1:3*CW];
			color_s1 <= {s_tdata[4*CW+CHAN_W-1:4*CW],
				s_tdata[4*CW+2*CHAN_W-1:4*CW+CHAN_W],
				s_tdata[4*CW+3*CHAN_W-1:4*CW+2*CHAN_W]};
		end
	end

	brl_engine #(
		.COORD_BITS(COORD_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.go          (go),
		.req_type    (req_s1),
		.start_x     (sx_s1),
		.start_y     (sy_s1),
		.end_x       (ex_s1),
		.end_y       (ey_s1),
		.color       (color_s1),
		.flags       (flags),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.word_address(word_address),
		.pixel_word  (pixel_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			flags_s2 <= flags;
			col_s2   <= pixel_col;
			row_s2   <= pixel_row;
			addr_s2  <= word_address;
			word_s2  <= pixel_word;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_W'({word_s2, addr_s2, row_s2, col_s2});
	assign m_tuser  = {flags_s2.write_enable, flags_s2.stepped};
	assign m_tlast  = flags_s2.last;

endmodule

`default_nettype wire

>>> src/brl_engine.sv
`default_nettype none

module brl_engine import brl_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [REG_W-1:0]        cfg_data,
	input  wire logic                    go,
	input  wire logic                    req_type,
	input  wire logic signed [COORD_BITS:0] start_x,
	input  wire logic signed [COORD_BITS:0] start_y,
	input  wire logic signed [COORD_BITS:0] end_x,
	input  wire logic signed [COORD_BITS:0] end_y,
	input  wire logic [COLOR_W-1:0]      color,
	output brl_flags_t                   flags,
	output logic signed [COORD_BITS:0]   pixel_col,
	output logic signed [COORD_BITS:0]   pixel_row,
	output logic [ADDR_W-1:0]            word_address,
	output logic [COLOR_W-1:0]           pixel_word
);

	localparam int CW = COORD_BITS + 1;
	localparam int DW = CW + 1;
	localparam int TW = CW + 1;
	localparam int EW = CW + 3;
	localparam int WW = (CW - 1 > REG_W) ? CW - 1 : REG_W;
	localparam int PW = (CW + REG_W > ADDR_W) ? CW + REG_W : ADDR_W;

	logic [REG_W-1:0] width_q, height_q, pitch_q;

	logic                 active_q, steep_q, dir_down_q;
	logic signed [CW-1:0] major_q, major_end_q, minor_q;
	logic signed [EW-1:0] err_q;
	logic [TW-1:0]        tdx_q, tdy_q;
	logic [COLOR_W-1:0]   color_q;

	// load path
	logic signed [DW-1:0] dx, dy, adx, ady, delta, mdiff, amd;
	logic                 steep, swap;
	logic signed [CW-1:0] sa, sb, ea, eb, a0, b0, a1, b1;

	// step path
	logic signed [CW-1:0] col, row;
	logic                 on_surface, fin, stepped;
	logic [WW-1:0]        col_u, row_u, wid_u, hgt_u;
	logic [PW-1:0]        addr_full;
	logic signed [EW-1:0] e1, e2;

	always_comb begin
		dx    = DW'(end_x) - DW'(start_x);
		dy    = DW'(end_y) - DW'(start_y);
		adx   = dx[DW-1] ? -dx : dx;
		ady   = dy[DW-1] ? -dy : dy;
		steep = ady > adx;
		sa    = steep ? start_y : start_x;
		sb    = steep ? start_x : start_y;
		ea    = steep ? end_y : end_x;
		eb    = steep ? end_x : end_y;
		swap  = sa > ea;
		a0    = swap ? ea : sa;
		b0    = swap ? eb : sb;
		a1    = swap ? sa : ea;
		b1    = swap ? sb : eb;
		delta = DW'(a1) - DW'(a0);
		mdiff = DW'(b1) - DW'(b0);
		amd   = mdiff[DW-1] ? -mdiff : mdiff;
	end

	always_comb begin
		col        = steep_q ? minor_q : major_q;
		row        = steep_q ? major_q : minor_q;
		col_u      = WW'(col[CW-2:0]);
		row_u      = WW'(row[CW-2:0]);
		wid_u      = WW'(width_q);
		hgt_u      = WW'(height_q);
		on_surface = !col[CW-1] && !row[CW-1] && (col_u < wid_u) && (row_u < hgt_u);
		fin        = (DW'(major_q) + DW'(1)) == DW'(major_end_q);
		addr_full  = PW'(row[CW-2:0]) * PW'(pitch_q) + PW'(col[CW-2:0]);
		stepped    = (req_type == REQ_STEP) && active_q;
		e1         = err_q - EW'(tdy_q);
		e2         = e1 + EW'(tdx_q);
	end

	always_comb begin
		flags.stepped      = stepped;
		flags.write_enable = stepped && on_surface;
		flags.last         = stepped && fin;
		pixel_col          = stepped ? col : '0;
		pixel_row          = stepped ? row : '0;
		word_address       = (stepped && on_surface) ? addr_full[ADDR_W-1:0] : '0;
		pixel_word         = stepped ? color_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_SURFACE_WIDTH;
			height_q <= RESET_SURFACE_HEIGHT;
			pitch_q  <= RESET_PITCH_WORDS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SURFACE_WIDTH:  width_q  <= cfg_data;
				REG_SURFACE_HEIGHT: height_q <= cfg_data;
				REG_PITCH_WORDS:    pitch_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			steep_q     <= 1'b0;
			dir_down_q  <= 1'b0;
			major_q     <= '0;
			major_end_q <= '0;
			minor_q     <= '0;
			err_q       <= '0;
			tdx_q       <= '0;
			tdy_q       <= '0;
			color_q     <= '0;
		end else if (go) begin
			if (req_type == REQ_LOAD) begin
				steep_q     <= steep;
				major_q     <= a0;
				major_end_q <= a1;
				minor_q     <= b0;
				dir_down_q  <= b0 < b1;
				tdx_q       <= {delta[CW-1:0], 1'b0};
				tdy_q       <= {amd[CW-1:0], 1'b0};
				err_q       <= EW'(delta);
				color_q     <= color;
				active_q    <= delta != '0;
			end else if (active_q) begin
				if (e1[EW-1]) begin
					minor_q <= dir_down_q ? minor_q + CW'(1) : minor_q - CW'(1);
					err_q   <= e2;
				end else begin
					err_q <= e1;
				end
				major_q <= major_q + CW'(1);
				if (fin) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> tb/bresenham_line_checker.sv
`timescale 1ns / 1ps

module bresenham_line_checker import brl_pkg::*; #(
	parameter int COORD_BITS = 12,
	localparam int CW    = COORD_BITS + 1,
	localparam int IN_W  = ((4 * CW + COLOR_W) + 7) / 8 * 8,
	localparam int OUT_W = ((2 * CW + ADDR_W + COLOR_W) + 7) / 8 * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	// start_x, start_y, end_x, end_y, red, green, blue
	input  wire logic [IN_W-1:0]      s_tdata,
	// req_type
	input  wire logic                 s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	// pixel_col, pixel_row, word_address, pixel_word
	input  wire logic [OUT_W-1:0]     m_tdata,
	// stepped, write_enable
	input  wire logic [1:0]           m_tuser,
	input  wire logic                 m_tlast,
	output int                        mismatches,
	output int                        outstanding,
	output int                        pixels_seen,
	output int                        pixels_inside,
	output int                        lines_ended
);

	typedef struct packed {
		logic               stepped;
		logic               write_enable;
		logic [CW-1:0]      col;
		logic [CW-1:0]      row;
		logic [ADDR_W-1:0]  address;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

	pixel_t expected_pixels[$];
	pixel_t seen;

	logic [REG_W-1:0]   width_reg, height_reg, pitch_reg;
	logic [COLOR_W-1:0] line_rgb;
	bit                 drawing, steep, minor_up;
	int                 major_at, major_stop, minor_at, err2, dx2, dy2;

	assign seen = {m_tuser[0], m_tuser[1], m_tdata[0 +: CW], m_tdata[CW +: CW],
		m_tdata[2*CW +: ADDR_W], m_tdata[2*CW+ADDR_W +: COLOR_W], m_tlast};

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic pixel_t rasterize(logic req, logic [IN_W-1:0] data);
		pixel_t      p;
		int          sx, sy, ex, ey, a0, b0, a1, b1, t, col, row;
		bit          on_surface;
		logic [31:0] addr;
		p = '0;
		if (req == REQ_LOAD) begin
			sx = $signed(data[0 +: CW]);
			sy = $signed(data[CW +: CW]);
			ex = $signed(data[2*CW +: CW]);
			ey = $signed(data[3*CW +: CW]);
			steep = magnitude(ey - sy) > magnitude(ex - sx);
			if (steep) begin
				a0 = sy; b0 = sx; a1 = ey; b1 = ex;
			end else begin
				a0 = sx; b0 = sy; a1 = ex; b1 = ey;
			end
			if (a0 > a1) begin
				t = a0; a0 = a1; a1 = t;
				t = b0; b0 = b1; b1 = t;
			end
			major_at   = a0;
			major_stop = a1;
			minor_at   = b0;
			minor_up   = b0 < b1;
			dx2        = 2 * (a1 - a0);
			dy2        = 2 * magnitude(b1 - b0);
			err2       = a1 - a0;
			line_rgb   = {data[4*CW +: CHAN_W], data[4*CW+CHAN_W +: CHAN_W],
				data[4*CW+2*CHAN_W +: CHAN_W]};
			drawing    = a1 > a0;
		end else if (drawing) begin
			col    = steep ? minor_at : major_at;
			row    = steep ? major_at : minor_at;
			on_surface = col >= 0 && col < int'(width_reg) &&
				row >= 0 && row < int'(height_reg);
			addr   = row * int'(pitch_reg) + col;
			p.stepped      = 1'b1;
			p.write_enable = on_surface;
			p.col          = CW'(col);
			p.row          = CW'(row);
			p.address      = on_surface ? addr[ADDR_W-1:0] : '0;
			p.color        = line_rgb;
			p.last         = (major_at + 1) == major_stop;
			err2 -= dy2;
			if (err2 < 0) begin
				minor_at += minor_up ? 1 : -1;
				err2 += dx2;
			end
			major_at++;
			if (p.last)
				drawing = 1'b0;
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			width_reg  = RESET_SURFACE_WIDTH;
			height_reg = RESET_SURFACE_HEIGHT;
			pitch_reg  = RESET_PITCH_WORDS;
			line_rgb   = '0;
			drawing    = 1'b0;
			steep      = 1'b0;
			minor_up   = 1'b0;
			major_at   = 0;
			major_stop = 0;
			minor_at   = 0;
			err2       = 0;
			dx2        = 0;
			dy2        = 0;
			expected_pixels.delete();
			mismatches    = 0;
			outstanding   = 0;
			pixels_seen   = 0;
			pixels_inside = 0;
			lines_ended   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SURFACE_WIDTH:  width_reg  = cfg_data;
					REG_SURFACE_HEIGHT: height_reg = cfg_data;
					REG_PITCH_WORDS:    pitch_reg  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_pixels.push_back(rasterize(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transaction with nothing expected", $time);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (seen !== want) begin
						if (mismatches < 10) begin
							$display("%0t: expected stepped=%b we=%b col=%0d row=%0d addr=%h rgb=%h last=%b",
								$time, want.stepped, want.write_enable, $signed(want.col),
								$signed(want.row), want.address, want.color, want.last);
							$display("%0t:      got stepped=%b we=%b col=%0d row=%0d addr=%h rgb=%h last=%b",
								$time, seen.stepped, seen.write_enable, $signed(seen.col),
								$signed(seen.row), seen.address, seen.color, seen.last);
						end
						mismatches++;
					end
					if (want.stepped)
						pixels_seen++;
					if (want.write_enable)
						pixels_inside++;
					if (want.last)
						lines_ended++;
				end
			end
			outstanding = expected_pixels.size();
		end
	end

endmodule

>>> tb/bresenham_line_rasterizer_top_test.sv
`timescale 1ns / 1ps

module bresenham_line_rasterizer_top_test;
	import brl_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int CW         = COORD_BITS + 1;
	localparam int IN_W       = ((4 * CW + COLOR_W) + 7) / 8 * 8;
	localparam int OUT_W      = ((2 * CW + ADDR_W + COLOR_W) + 7) / 8 * 8;
	localparam int COORD_MIN  = -(1 << COORD_BITS);
	localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
	localparam int REG_MAX    = (1 << REG_W) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;

	int mismatches, outstanding, pixels_seen, pixels_inside, lines_ended;
	int items_sent     = 0;
	int settings_used  = 1;
	int surf_w         = 640;
	int surf_h         = 480;
	int stall_left     = 0;
	bit calm_source    = 1'b0;
	bit calm_sink      = 1'b0;

	bresenham_line_rasterizer_top #(.COORD_BITS(COORD_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	bresenham_line_checker #(.COORD_BITS(COORD_BITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches), .outstanding(outstanding), .pixels_seen(pixels_seen),
		.pixels_inside(pixels_inside), .lines_ended(lines_ended)
	);

	always #10 clk = ~clk;

	initial begin
		#(30_000_000);
		$display("bresenham_line_rasterizer_top test failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_coord(int v);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
	endfunction

	// mostly around the visible area so clipping edges get hit
	function automatic int near_coord(int limit);
		return clamp_coord(int'($urandom_range(0, limit + 15)) - 8);
	endfunction

	function automatic int distance(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!calm_sink && $urandom_range(0, 2) == 0) begin
			m_tready <= 1'b0;
			stall_left = pick_gap();
		end else
			m_tready <= 1'b1;
	end

	task automatic send(logic req, int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] rgb);
		int gap;
		gap = calm_source ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= req;
		s_tdata  <= IN_W'({rgb[0 +: CHAN_W], rgb[CHAN_W +: CHAN_W], rgb[2*CHAN_W +: CHAN_W],
			CW'(ey), CW'(ex), CW'(sy), CW'(sx)});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// endpoint and color fields are don't-care on a step
	task automatic send_step();
		send(REQ_STEP, any_coord(), any_coord(), any_coord(), any_coord(), COLOR_W'($urandom));
	endtask

	task automatic set_surface(int w, int h, int p);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SURFACE_WIDTH;
		cfg_data  <= REG_W'(w);
		@(negedge clk);
		cfg_index <= REG_SURFACE_HEIGHT;
		cfg_data  <= REG_W'(h);
		@(negedge clk);
		cfg_index <= REG_PITCH_WORDS;
		cfg_data  <= REG_W'(p);
		@(negedge clk);
		cfg_we    <= 1'b0;
		surf_w = w;
		surf_h = h;
		settings_used++;
		calm_source = ($urandom_range(0, 3) == 0);
		calm_sink   = ($urandom_range(0, 3) == 0);
	endtask

	task automatic random_traffic(int count);
		int stop_at, sx, sy, ex, ey, span, steps, pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				if ($urandom_range(0, 9) < 7) begin
					sx = near_coord(surf_w);
					sy = near_coord(surf_h);
				end else begin
					sx = any_coord();
					sy = any_coord();
				end
				span = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 12) : $urandom_range(13, 150);
				ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
				ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
				steps = (distance(ex, sx) > distance(ey, sy)) ? distance(ex, sx) : distance(ey, sy);
				send(REQ_LOAD, sx, sy, ex, ey, COLOR_W'($urandom));
				pick = $urandom_range(0, 9);
				if (pick == 0)
					steps = $urandom_range(0, steps);
				else if (pick == 1)
					steps += $urandom_range(1, 3);
				repeat (steps) send_step();
			end else if (pick < 93)
				send_step();
			else
				send(REQ_LOAD, any_coord(), any_coord(), any_coord(), any_coord(),
					COLOR_W'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_step();
		send(REQ_LOAD, 5, 5, 5, 5, 24'h123456);
		send_step();
		send(REQ_LOAD, 0, 0, 5, 2, 24'hFFFFFF);
		repeat (5) send_step();
		send(REQ_LOAD, 3, 0, 1, 6, 24'h3C5A96);
		repeat (6) send_step();
		send(REQ_LOAD, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 24'hA5C30F);
		repeat (2) send_step();
		// replaces the long line mid-flight and crosses the right and bottom edges
		send(REQ_LOAD, 639, 479, 642, 481, 24'h000000);
		repeat (3) send_step();
		send_step();

		set_surface(1, 1, 1);
		random_traffic(250);
		set_surface(4096, 4096, 4096);
		random_traffic(250);
		set_surface(REG_MAX, REG_MAX, REG_MAX);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data  <= REG_W'($urandom);
		@(negedge clk);
		cfg_we    <= 1'b0;
		random_traffic(200);
		set_surface(0, 0, 0);
		random_traffic(150);
		repeat (3) begin
			set_surface($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 4096));
			random_traffic(250);
		end
		set_surface(640, 480, 640);
		random_traffic(150);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d input transactions over %0d surface settings, range extremes included.",
			items_sent, settings_used);
		$display("Checked %0d pixels, %0d inside the surface, %0d lines drawn to their end.",
			pixels_seen, pixels_inside, lines_ended);
		if (mismatches == 0 && outstanding == 0)
			$display("bresenham_line_rasterizer_top test passed");
		else
			$display("bresenham_line_rasterizer_top test failed");
		$finish;
	end

endmodule
